@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for vlpd_decode; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define VLPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vlpd assertion failed");

`define VLPD_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("vlpd forbidden condition");

`else

`define VLPD_ASSERT(lbl, clk, rst_n, prop)

`define VLPD_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ rtl/core/vlpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlpd_pkg
// Types and constants of the varint length-prefix deframer.
// ----------------------------------------------------------------------------
package vlpd_pkg;

  localparam int MAX_HEADER_BYTES = 5;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 24;
  localparam int GROUP_BITS  = 7;
  localparam int MORE_BIT    = 7;
  localparam int GROUP_LIMIT = (LEN_W + GROUP_BITS - 1) / GROUP_BITS;
  localparam int ACC_W       = GROUP_BITS * GROUP_LIMIT;
  localparam int SHIFT_W     = $clog2(ACC_W);
  localparam int GI_W        = $clog2(MAX_HEADER_BYTES + 1);

  localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7f;
  localparam logic [BYTE_W-1:0] MORE_FLAG  = 8'h80;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd65536;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_MAX_LEN = 1'b0;

  typedef enum logic [2:0] {
    ST_HDR_MORE = 3'd0,
    ST_HDR_DONE = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_PAYLOAD  = 3'd3,
    ST_ERROR    = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              link_error;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  message_length;
    logic              last_of_message;
  } out_word_t;

endpackage

@@ rtl/core/varint_length_prefix_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_length_prefix_deframer
// Splits a byte stream into messages framed by base-128 varint length prefixes.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_data carries one stream byte and a link-error flag per word;
//   in_stall holds the sender off. out_valid/out_data returns exactly one
//   status word per input word: prefix byte, prefix done with length, empty
//   message, payload byte with last marker, or error.
//   cfg_* is an APB-style port; register 0 at byte address 0 is the maximum
//   payload length (24 bits, reset 65536). Write it only while idle.
// Path: an accepted word passes the input register, then the output register.
// Throughput: one word per cycle while out_stall is low; the only loop is the
//   frame state update between the input register and the output register.
// Reset (rst_n low, synchronous): both registers empty, frame state expects a
//   prefix, error latch cleared. Errors stay latched until the next reset.
// When out_stall is high the output word holds; the input register still
//   takes one more word, then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module varint_length_prefix_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vlpd_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vlpd_pkg::out_word_t              out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [vlpd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [vlpd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [vlpd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  logic                       in_valid_r, in_valid_nxt;
  vlpd_pkg::in_word_t         in_word_r, in_word_nxt;
  logic                       out_valid_r, out_valid_nxt;
  vlpd_pkg::out_word_t        out_word_r, out_word_nxt;
  logic                       advance;
  logic                       accept;
  logic                       step;
  logic [vlpd_pkg::LEN_W-1:0] max_len;
  vlpd_pkg::out_word_t        result;

  vlpd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  vlpd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_word_r),
    .max_len (max_len),
    .result  (result)
  );

  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_word_nxt  = in_word_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
      in_word_nxt  = in_data;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = result;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_word_r  <= in_word_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

@@ rtl/core/vlpd_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlpd_cfg_regs
// APB-style register file holding the maximum message length.
// ----------------------------------------------------------------------------
module vlpd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [vlpd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [vlpd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [vlpd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output logic [vlpd_pkg::LEN_W-1:0]       max_len
);

  logic [vlpd_pkg::LEN_W-1:0] max_len_r;
  logic [vlpd_pkg::LEN_W-1:0] max_len_nxt;
  logic                       wr_en;
  logic                       reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en && (reg_idx == vlpd_pkg::CFG_IDX_MAX_LEN)) begin
      max_len_nxt = cfg_pwdata[vlpd_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      vlpd_pkg::CFG_IDX_MAX_LEN:
        cfg_prdata = vlpd_pkg::CFG_DATA_W'(max_len_r);
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= vlpd_pkg::MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  assign max_len = max_len_r;

endmodule

@@ rtl/core/vlpd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlpd_decode
// Per-byte frame state update: prefix accumulation, payload count, error latch.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vlpd_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  vlpd_pkg::in_word_t         in_word,
  input  logic [vlpd_pkg::LEN_W-1:0] max_len,
  output vlpd_pkg::out_word_t        result
);

  logic                          in_header_r, in_header_nxt;
  logic [vlpd_pkg::GI_W-1:0]     group_idx_r, group_idx_nxt;
  logic [vlpd_pkg::LEN_W-1:0]    accum_r, accum_nxt;
  logic [vlpd_pkg::LEN_W-1:0]    remain_r, remain_nxt;
  logic                          err_r, err_nxt;

  logic [vlpd_pkg::GROUP_BITS-1:0] grp;
  logic                            more;
  logic                            shift_ok;
  logic [vlpd_pkg::SHIFT_W-1:0]    shift_amt;
  logic [vlpd_pkg::ACC_W-1:0]      shifted;
  logic [vlpd_pkg::ACC_W-1:0]      acc_wide;
  logic [vlpd_pkg::LEN_W-1:0]      remain_dec;

  assign grp       = vlpd_pkg::GROUP_BITS'(in_word.data_byte & vlpd_pkg::GROUP_MASK);
  assign more      = (in_word.data_byte & vlpd_pkg::MORE_FLAG) != '0;
  assign shift_ok  = group_idx_r < vlpd_pkg::GI_W'(vlpd_pkg::GROUP_LIMIT);
  assign shift_amt = vlpd_pkg::SHIFT_W'(group_idx_r) *
                     vlpd_pkg::SHIFT_W'(vlpd_pkg::GROUP_BITS);
  assign shifted   = shift_ok ? (vlpd_pkg::ACC_W'(grp) << shift_amt) : '0;
  assign acc_wide  = vlpd_pkg::ACC_W'(accum_r) | shifted;
  assign remain_dec = (remain_r == '0) ? '0 : remain_r - 1'b1;

  always_comb begin
    in_header_nxt = in_header_r;
    group_idx_nxt = group_idx_r;
    accum_nxt     = accum_r;
    remain_nxt    = remain_r;
    err_nxt       = err_r;
    result        = '0;
    result.status = vlpd_pkg::ST_ERROR;
    if (step) begin
      if (err_r) begin
        result.status = vlpd_pkg::ST_ERROR;
      end else if (in_word.link_error) begin
        err_nxt = 1'b1;
      end else if (in_header_r) begin
        if (group_idx_r >= vlpd_pkg::GI_W'(vlpd_pkg::MAX_HEADER_BYTES)) begin
          err_nxt = 1'b1;
        end else if ((grp != '0) && !shift_ok) begin
          err_nxt = 1'b1;
        end else if (acc_wide > vlpd_pkg::ACC_W'(max_len)) begin
          err_nxt = 1'b1;
        end else if (more) begin
          group_idx_nxt = group_idx_r + 1'b1;
          accum_nxt     = acc_wide[vlpd_pkg::LEN_W-1:0];
          result.status = vlpd_pkg::ST_HDR_MORE;
        end else begin
          group_idx_nxt = '0;
          accum_nxt     = '0;
          if (acc_wide != '0) begin
            remain_nxt            = acc_wide[vlpd_pkg::LEN_W-1:0];
            in_header_nxt         = 1'b0;
            result.status         = vlpd_pkg::ST_HDR_DONE;
            result.message_length = acc_wide[vlpd_pkg::LEN_W-1:0];
          end else begin
            result.status = vlpd_pkg::ST_EMPTY;
          end
        end
      end else begin
        remain_nxt          = remain_dec;
        result.status       = vlpd_pkg::ST_PAYLOAD;
        result.payload_byte = in_word.data_byte;
        if (remain_dec == '0) begin
          in_header_nxt          = 1'b1;
          result.last_of_message = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_header_r <= 1'b1;
      group_idx_r <= '0;
      accum_r     <= '0;
      remain_r    <= '0;
      err_r       <= 1'b0;
    end else begin
      in_header_r <= in_header_nxt;
      group_idx_r <= group_idx_nxt;
      accum_r     <= accum_nxt;
      remain_r    <= remain_nxt;
      err_r       <= err_nxt;
    end
  end

  `VLPD_ASSERT(a_err_sticky, clk, rst_n, err_r |=> err_r)
  `VLPD_NEVER(a_payload_count, clk, rst_n, !in_header_r && (remain_r == '0))
  `VLPD_NEVER(a_group_range, clk, rst_n,
    group_idx_r > vlpd_pkg::GI_W'(vlpd_pkg::MAX_HEADER_BYTES))
  `VLPD_ASSERT(a_err_sets_latch, clk, rst_n,
    (step && (result.status == vlpd_pkg::ST_ERROR)) |=> err_r)

endmodule

@@ verif/varint_length_prefix_deframer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_length_prefix_deframer_test
// Self-checking bench for the varint length-prefix deframer. A directed table
// of stream bytes runs first, then randomly framed messages under several
// maximum-length settings, and the run closes by forcing one sticky error.
// Status words are checked in order against a local deframer model, or typed
// table rows against the table; both channels idle and stall but when calm.
// ----------------------------------------------------------------------------
module varint_length_prefix_deframer_test;

  typedef struct {
    logic [vlpd_pkg::BYTE_W-1:0] data;
    bit                          typed;
    vlpd_pkg::status_t           st;
    logic [vlpd_pkg::BYTE_W-1:0] pb;
    logic [vlpd_pkg::LEN_W-1:0]  len;
    logic                        last;
  } byte_row_t;

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            in_stall;
  vlpd_pkg::in_word_t              in_data     = '0;
  logic                            out_valid;
  logic                            out_stall   = 1'b0;
  vlpd_pkg::out_word_t             out_data;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [vlpd_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [vlpd_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [vlpd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // deframer model state
  bit                         hdr_mode   = 1'b1;
  int                         grp_count  = 0;
  logic [34:0]                len_acc    = '0;
  logic [vlpd_pkg::LEN_W-1:0] pay_left   = '0;
  bit                         err_sticky = 1'b0;
  logic [vlpd_pkg::LEN_W-1:0] max_len    = vlpd_pkg::MAX_LEN_RESET;

  vlpd_pkg::out_word_t expected_status_words[$];
  int                  words_sent = 0;
  int                  fail_count = 0;
  bit                  calm       = 1'b0;

  byte_row_t byte_rows[20] = '{
    '{8'h00, 1'b1, vlpd_pkg::ST_EMPTY,    8'h00, 24'd0, 1'b0},
    '{8'h80, 1'b1, vlpd_pkg::ST_HDR_MORE, 8'h00, 24'd0, 1'b0},
    '{8'h80, 1'b1, vlpd_pkg::ST_HDR_MORE, 8'h00, 24'd0, 1'b0},
    '{8'h80, 1'b1, vlpd_pkg::ST_HDR_MORE, 8'h00, 24'd0, 1'b0},
    '{8'h80, 1'b1, vlpd_pkg::ST_HDR_MORE, 8'h00, 24'd0, 1'b0},
    '{8'h00, 1'b1, vlpd_pkg::ST_EMPTY,    8'h00, 24'd0, 1'b0},
    '{8'h01, 1'b1, vlpd_pkg::ST_HDR_DONE, 8'h00, 24'd1, 1'b0},
    '{8'ha5, 1'b1, vlpd_pkg::ST_PAYLOAD,  8'ha5, 24'd0, 1'b1},
    '{8'h83, 1'b1, vlpd_pkg::ST_HDR_MORE, 8'h00, 24'd0, 1'b0},
    '{8'h00, 1'b1, vlpd_pkg::ST_HDR_DONE, 8'h00, 24'd3, 1'b0},
    '{8'hff, 1'b1, vlpd_pkg::ST_PAYLOAD,  8'hff, 24'd0, 1'b0},
    '{8'h00, 1'b1, vlpd_pkg::ST_PAYLOAD,  8'h00, 24'd0, 1'b0},
    '{8'h80, 1'b1, vlpd_pkg::ST_PAYLOAD,  8'h80, 24'd0, 1'b1},
    '{8'h81, 1'b0, vlpd_pkg::ST_HDR_MORE, 8'h00, 24'd0, 1'b0},
    '{8'h80, 1'b0, vlpd_pkg::ST_HDR_MORE, 8'h00, 24'd0, 1'b0},
    '{8'h00, 1'b0, vlpd_pkg::ST_HDR_DONE, 8'h00, 24'd0, 1'b0},
    '{8'h7f, 1'b0, vlpd_pkg::ST_PAYLOAD,  8'h00, 24'd0, 1'b0},
    '{8'h02, 1'b1, vlpd_pkg::ST_HDR_DONE, 8'h00, 24'd2, 1'b0},
    '{8'h01, 1'b0, vlpd_pkg::ST_PAYLOAD,  8'h00, 24'd0, 1'b0},
    '{8'hfe, 1'b0, vlpd_pkg::ST_PAYLOAD,  8'h00, 24'd0, 1'b0}
  };

  varint_length_prefix_deframer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[varint_length_prefix_deframer] ERROR");
    $finish;
  end

  function automatic vlpd_pkg::out_word_t predict_status_word(vlpd_pkg::in_word_t w);
    vlpd_pkg::out_word_t r;
    logic [6:0]          grp;
    int                  shift;
    r = '0;
    r.status = vlpd_pkg::ST_ERROR;
    if (err_sticky) return r;
    if (w.link_error) begin
      err_sticky = 1'b1;
      return r;
    end
    if (hdr_mode) begin
      if (grp_count >= vlpd_pkg::MAX_HEADER_BYTES) begin
        err_sticky = 1'b1;
        return r;
      end
      grp   = w.data_byte[6:0];
      shift = vlpd_pkg::GROUP_BITS * grp_count;
      if (grp != 0) begin
        if (shift >= vlpd_pkg::LEN_W) begin
          err_sticky = 1'b1;
          return r;
        end
        len_acc = len_acc | (35'(grp) << shift);
      end
      if (len_acc > 35'(max_len)) begin
        err_sticky = 1'b1;
        return r;
      end
      if ((w.data_byte & vlpd_pkg::MORE_FLAG) != 0) begin
        grp_count++;
        r.status = vlpd_pkg::ST_HDR_MORE;
        return r;
      end
      grp_count = 0;
      if (len_acc != 0) begin
        pay_left = len_acc[vlpd_pkg::LEN_W-1:0];
        hdr_mode = 1'b0;
        r.status = vlpd_pkg::ST_HDR_DONE;
        r.message_length = len_acc[vlpd_pkg::LEN_W-1:0];
      end else begin
        r.status = vlpd_pkg::ST_EMPTY;
      end
      len_acc = '0;
      return r;
    end
    if (pay_left > 0) pay_left--;
    r.status = vlpd_pkg::ST_PAYLOAD;
    r.payload_byte = w.data_byte;
    if (pay_left == 0) begin
      hdr_mode = 1'b1;
      r.last_of_message = 1'b1;
    end
    return r;
  endfunction

  task automatic send_word(vlpd_pkg::in_word_t w, bit typed,
                           vlpd_pkg::out_word_t typed_exp);
    vlpd_pkg::out_word_t predicted;
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predicted = predict_status_word(w);
    expected_status_words.push_back(typed ? typed_exp : predicted);
    words_sent++;
  endtask

  task automatic send_byte(logic [vlpd_pkg::BYTE_W-1:0] b, logic link);
    vlpd_pkg::in_word_t w;
    w.data_byte  = b;
    w.link_error = link;
    send_word(w, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_status_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max_len(logic [vlpd_pkg::LEN_W-1:0] v);
    logic [vlpd_pkg::CFG_DATA_W-1:0] rd;
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= vlpd_pkg::CFG_ADDR_W'(4 * vlpd_pkg::CFG_IDX_MAX_LEN);
    cfg_pwdata  <= vlpd_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    max_len = v;
    // read back
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== vlpd_pkg::CFG_DATA_W'(v)) begin
      fail_count++;
      $display("%0t max_len readback: expected %06h, got %08h", $time, v, rd);
    end
  endtask

  task automatic send_header(int unsigned len, bit padded);
    logic [vlpd_pkg::BYTE_W-1:0] hdr[$];
    int unsigned                 v;
    int                          n_pad;
    v = len;
    do begin
      hdr.push_back(vlpd_pkg::BYTE_W'(v[6:0]));
      v = v >> vlpd_pkg::GROUP_BITS;
    end while (v != 0);
    n_pad = 0;
    if (padded && hdr.size() < vlpd_pkg::MAX_HEADER_BYTES && $urandom_range(0, 99) < 40)
      n_pad = $urandom_range(1, vlpd_pkg::MAX_HEADER_BYTES - hdr.size());
    repeat (n_pad) hdr.push_back(8'h00);
    for (int i = 0; i < hdr.size() - 1; i++) hdr[i] = hdr[i] | vlpd_pkg::MORE_FLAG;
    foreach (hdr[i]) send_byte(hdr[i], 1'b0);
  endtask

  task automatic send_message(int unsigned len);
    int r;
    send_header(len, 1'b1);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      send_byte((r < 10) ? 8'h00 : (r < 20) ? 8'hff : vlpd_pkg::BYTE_W'($urandom),
                1'b0);
    end
  endtask

  function automatic int unsigned pick_length();
    int          r;
    int unsigned cap;
    r   = $urandom_range(0, 99);
    cap = (max_len < 40) ? max_len : 40;
    if (r < 15) return 0;
    if (r < 22) return (max_len < 300) ? max_len : 300;
    return $urandom_range(0, cap);
  endfunction

  task automatic raise_error();
    case ($urandom_range(0, 3))
      0: begin
        write_max_len(24'hffffff);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h07, 1'b0);
        repeat ($urandom_range(0, 5)) send_byte(vlpd_pkg::BYTE_W'($urandom), 1'b0);
        send_byte(vlpd_pkg::BYTE_W'($urandom), 1'b1);
      end
      1: begin
        repeat (vlpd_pkg::MAX_HEADER_BYTES) send_byte(8'h80, 1'b0);
        send_byte(vlpd_pkg::BYTE_W'($urandom), 1'b0);
      end
      2: begin
        repeat (vlpd_pkg::MAX_HEADER_BYTES - 1) send_byte(8'h80, 1'b0);
        send_byte({1'($urandom), 7'($urandom_range(1, 127))}, 1'b0);
      end
      default: begin
        write_max_len(vlpd_pkg::LEN_W'($urandom_range(0, 5000)));
        send_header(max_len + $urandom_range(1, 2000), 1'b0);
      end
    endcase
    send_byte(vlpd_pkg::BYTE_W'($urandom), 1'b1);
    repeat (19) send_byte(vlpd_pkg::BYTE_W'($urandom), 1'($urandom));
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  always @(posedge clk) begin
    vlpd_pkg::out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status_words.size() == 0) begin
        fail_count++;
        $display("%0t unexpected word: status=%0d byte=%02h len=%0d last=%0b",
                 $time, out_data.status, out_data.payload_byte,
                 out_data.message_length, out_data.last_of_message);
      end else begin
        exp_w = expected_status_words.pop_front();
        if (out_data.status !== exp_w.status ||
            out_data.payload_byte !== exp_w.payload_byte ||
            out_data.message_length !== exp_w.message_length ||
            out_data.last_of_message !== exp_w.last_of_message) begin
          fail_count++;
          $display("%0t expected %0d/%02h/%0d/%0b, got %0d/%02h/%0d/%0b",
                   $time, exp_w.status, exp_w.payload_byte, exp_w.message_length,
                   exp_w.last_of_message, out_data.status, out_data.payload_byte,
                   out_data.message_length, out_data.last_of_message);
        end
      end
    end
  end

  initial begin
    vlpd_pkg::in_word_t          w;
    vlpd_pkg::out_word_t         e;
    logic [vlpd_pkg::LEN_W-1:0]  phase_max[6];
    int                          target;
    phase_max = '{24'd0, 24'd1, 24'd127, 24'd128, 24'd0, 24'hffffff};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (byte_rows[i]) begin
      w.data_byte  = byte_rows[i].data;
      w.link_error = 1'b0;
      e = '0;
      e.status          = byte_rows[i].st;
      e.payload_byte    = byte_rows[i].pb;
      e.message_length  = byte_rows[i].len;
      e.last_of_message = byte_rows[i].last;
      send_word(w, byte_rows[i].typed, e);
    end

    for (int p = 0; p < 6; p++) begin
      write_max_len((p == 4) ? vlpd_pkg::LEN_W'($urandom_range(2, 400)) : phase_max[p]);
      calm = (p == 5);
      target = words_sent + 140;
      while (words_sent < target) send_message(pick_length());
    end
    calm = 1'b0;

    raise_error();

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_status_words.size() == 0)
      $display("[varint_length_prefix_deframer] OK");
    else
      $display("[varint_length_prefix_deframer] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/vlpd_pkg.sv
rtl/core/vlpd_cfg_regs.sv
rtl/core/vlpd_decode.sv
rtl/core/varint_length_prefix_deframer.sv
verif/varint_length_prefix_deframer_test.sv
